@@ hdl/cba_pkg.sv @@
// Package for the contiguous block allocator.
// Holds field widths, status and mode codes, FSM state type and the cell command struct.
// No dependencies.
package cba_pkg;

	localparam int DEF_NUM_BLOCKS = 32;

	localparam int MODE_W   = 1;
	localparam int COUNT_W  = 6;
	localparam int BLOCK_W  = 9;
	localparam int STATUS_W = 2;
	localparam int OFFS_W   = 8;

	// Range compare width inside the cells; covers up to 1024 blocks plus one.
	localparam int RANGE_W = 11;

	localparam logic [OFFS_W-1:0] RESET_OFFSET = 8'd4;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_APPLY,
		S_RESP
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               apply;
		logic               set;
		logic [RANGE_W-1:0] lo;
		logic [RANGE_W-1:0] hi;
	} cmd_t;

endpackage

@@ hdl/cba_if.sv @@
// Handshake interfaces for the allocator: request, response and configuration write.
// Depends on cba_pkg.
interface cba_req_if;
	import cba_pkg::*;
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [COUNT_W-1:0] block_count;
	logic [BLOCK_W-1:0] first_block;
	modport source (output valid, mode, block_count, first_block, input ready);
	modport sink (input valid, mode, block_count, first_block, output ready);
endinterface

interface cba_resp_if;
	import cba_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BLOCK_W-1:0]  run_start;
	modport source (output valid, status, run_start, input ready);
	modport sink (input valid, status, run_start, output ready);
endinterface

interface cba_cfg_if;
	import cba_pkg::*;
	logic              valid;
	logic              ready;
	logic [OFFS_W-1:0] reserved_offset;
	modport source (output valid, reserved_offset, input ready);
	modport sink (input valid, reserved_offset, output ready);
endinterface

@@ hdl/cba_cell.sv @@
// One bitmap cell: holds the used bit of one block and passes the scan wave on.
// Depends on cba_pkg.
module cba_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cba_pkg::cmd_t               cmd,
	input  logic                        act_in,
	input  logic [cba_pkg::COUNT_W-1:0] run_in,
	output logic                        act_out,
	output logic [cba_pkg::COUNT_W-1:0] run_out,
	output logic                        hit
);
	import cba_pkg::*;

	logic               used_q;
	logic               act_q;
	logic [COUNT_W-1:0] run_q;
	logic               in_range;

	// run_out is the length of the free run ending at this block
	assign run_out  = used_q ? '0 : run_q + COUNT_W'(1);
	assign hit      = act_q && !used_q && (run_out == cmd.count);
	assign act_out  = act_q && !hit;
	assign in_range = (RANGE_W'(IDX) >= cmd.lo) && (RANGE_W'(IDX) <= cmd.hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else begin
			act_q <= act_in;
			if (cmd.apply && in_range) begin
				used_q <= cmd.set;
			end
		end
	end

	always_ff @(posedge clk) begin
		run_q <= run_in;
	end

endmodule

@@ hdl/cba_chain.sv @@
// Row of bitmap cells linked for the first-fit scan wave.
// Depends on cba_pkg and cba_cell.
module cba_chain #(
	parameter int NUM_BLOCKS = cba_pkg::DEF_NUM_BLOCKS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cba_pkg::cmd_t cmd,
	input  logic          start,
	output logic          hit_any
);
	import cba_pkg::*;

	logic               act_link [NUM_BLOCKS+1];
	logic [COUNT_W-1:0] run_link [NUM_BLOCKS+1];
	logic [NUM_BLOCKS-1:0] hits;

	assign act_link[0] = start;
	assign run_link[0] = '0;

	for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
		cba_cell #(.IDX(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.act_in  (act_link[k]),
			.run_in  (run_link[k]),
			.act_out (act_link[k+1]),
			.run_out (run_link[k+1]),
			.hit     (hits[k])
		);
	end

	// only one cell carries the wave, so at most one hit bit is set
	assign hit_any = |hits;

endmodule

@@ hdl/contiguous_block_allocator.sv @@
// Contiguous block allocator: first-fit bitmap over a row of cells.
// Allocate: a scan wave moves one cell per cycle; on a hit S_APPLY marks the run used, and
// S_RESP loads the result into the response register once it is free or being read.
// Free: S_CHECK, then S_APPLY unless the range is bad, then S_RESP; zero count goes to S_RESP.
// One request at a time; the next beat is taken the cycle after the result is loaded, even while
// that result waits. Reset (arst_n low) frees every block and sets reserved_offset to 4.
module contiguous_block_allocator #(
	parameter int NUM_BLOCKS = cba_pkg::DEF_NUM_BLOCKS
) (
	input logic        clk,
	input logic        arst_n,
	cba_req_if.sink    req,
	cba_resp_if.source resp,
	cba_cfg_if.sink    cfg
);
	import cba_pkg::*;

	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int RW = RANGE_W;

	state_t state_q, state_d;

	logic [COUNT_W-1:0]  n_q;
	logic [BLOCK_W-1:0]  first_q;
	logic [IW-1:0]       idx_q;
	logic [RW-1:0]       lo_q, hi_q;
	logic                set_q;
	logic [STATUS_W-1:0] status_q;
	logic [BLOCK_W-1:0]  start_q;
	logic [OFFS_W-1:0]   offset_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [BLOCK_W-1:0]  out_start_q;

	logic   accept, start_scan, load_out, hit_any, scan_last, free_bad;
	logic [RW-1:0] scan_lo, alloc_start, free_base, free_end;
	cmd_t   cmd;

	assign accept    = req.valid && req.ready;
	assign scan_last = (idx_q == IW'(NUM_BLOCKS - 1));
	assign scan_lo   = RW'(idx_q) + RW'(1) - RW'(n_q);
	assign alloc_start = scan_lo + RW'(offset_q);
	assign free_base = RW'(first_q) - RW'(offset_q);
	assign free_end  = free_base + RW'(n_q);
	assign free_bad  = (RW'(first_q) < RW'(offset_q)) || (free_end > RW'(NUM_BLOCKS));

	assign cmd.count = n_q;
	assign cmd.apply = (state_q == S_APPLY);
	assign cmd.set   = set_q;
	assign cmd.lo    = lo_q;
	assign cmd.hi    = hi_q;

	cba_chain #(.NUM_BLOCKS(NUM_BLOCKS)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.start   (start_scan),
		.hit_any (hit_any)
	);

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		start_scan = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.block_count == '0) begin
						state_d = S_RESP;
					end else if (req.mode == MODE_ALLOC) begin
						state_d    = S_SCAN;
						start_scan = 1'b1;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_SCAN: begin
				if (hit_any) begin
					state_d = S_APPLY;
				end else if (scan_last) begin
					state_d = S_RESP;
				end
			end
			S_CHECK: begin
				state_d = free_bad ? S_RESP : S_APPLY;
			end
			S_APPLY: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || resp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q      <= req.block_count;
			first_q  <= req.first_block;
			idx_q    <= '0;
			start_q  <= '0;
			status_q <= ST_BAD;
		end
		if (state_q == S_SCAN) begin
			idx_q <= idx_q + IW'(1);
			if (hit_any) begin
				lo_q     <= scan_lo;
				hi_q     <= RW'(idx_q);
				set_q    <= 1'b1;
				status_q <= ST_OK;
				start_q  <= alloc_start[BLOCK_W-1:0];
			end else if (scan_last) begin
				status_q <= ST_NOSPACE;
			end
		end
		if (state_q == S_CHECK && !free_bad) begin
			lo_q     <= free_base;
			hi_q     <= free_end - RW'(1);
			set_q    <= 1'b0;
			status_q <= ST_OK;
		end
		if (load_out) begin
			out_status_q <= status_q;
			out_start_q  <= start_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= RESET_OFFSET;
		end else if (cfg.valid) begin
			offset_q <= cfg.reserved_offset;
		end
	end

	assign cfg.ready      = 1'b1;
	assign resp.valid     = out_valid_q;
	assign resp.status    = out_status_q;
	assign resp.run_start = out_start_q;

	// the scan wave exists only while the controller is scanning
	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_any |-> state_q == S_SCAN)
		else $error("cell hit outside scan");

	// the range written to the cells always spans exactly the requested count
	a_apply_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |-> (hi_q - lo_q + RW'(1)) == RW'(n_q))
		else $error("apply range does not match block count");

	// a failed request never reports a start block
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_start_q == '0)
		else $error("nonzero start block on failed request");

	// one request at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while busy");

endmodule
